// ===== hdl/b64enc_pkg.sv =====
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
// Depends on nothing; every other file in hdl/ refers to it by scoped names.
`default_nettype none

package b64enc_pkg;

  // Most characters a single input byte can produce (final byte at group start).
  localparam int unsigned MAX_SYMS     = 4;
  localparam int unsigned SYM_IDX_W    = $clog2(MAX_SYMS);
  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  // ASCII codes used by the alphabet and the pad.
  localparam logic [7:0] PAD_CHAR      = 8'h3D;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_PLUS    = 8'h2B;
  localparam logic [7:0] ASCII_SLASH   = 8'h2F;

  // Input beat: one raw message byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_beat_t;

  // Output beat: one encoded character.
  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_beat_t;

  // One pending character: a six-bit alphabet index or a pad.
  typedef struct packed {
    logic       pad;
    logic [5:0] idx;
  } sym_t;

  // Work for the back: the characters of one byte, slot 0 first.
  typedef struct packed {
    sym_t [MAX_SYMS-1:0]  syms;
    logic [SYM_IDX_W-1:0] last_idx;  // slot of the final character
    logic                 fin;       // final character closes the message
  } entry_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic valid;
  } queue_stat_t;

  // Maps a six-bit value onto the standard base64 alphabet.
  function automatic logic [7:0] sym_to_ascii(input logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      sym_to_ascii = ASCII_UPPER_A + v8;
    end else if (v < 6'd52) begin
      sym_to_ascii = ASCII_LOWER_A + v8 - 8'd26;
    end else if (v < 6'd62) begin
      sym_to_ascii = ASCII_ZERO + v8 - 8'd52;
    end else if (v == 6'd62) begin
      sym_to_ascii = ASCII_PLUS;
    end else begin
      sym_to_ascii = ASCII_SLASH;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/b64enc_front.sv =====
// Front of the encoder: accepts bytes, tracks the group phase and carry bits,
// and turns each byte into a queue entry of characters. Uses b64enc_pkg.
`default_nettype none

module b64enc_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire b64enc_pkg::in_beat_t in_data,
  input  wire b64enc_pkg::queue_stat_t q_stat,
  output logic                      q_push,
  output b64enc_pkg::entry_t        q_wdata
);

  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;
  logic [7:0] b;
  logic       fin;

  // A beat is taken whenever the queue has room.
  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && !q_stat.full;
  assign b        = in_data.data_byte;
  assign fin      = in_data.end_of_message;

  // Split the byte into characters according to its place in the group.
  always_comb begin
    q_wdata          = '0;
    q_wdata.fin      = fin;
    phase_nxt        = PH_0;
    carry_nxt        = 4'd0;
    case (phase_r)
      PH_1: begin
        q_wdata.syms[0] = '{pad: 1'b0, idx: {carry_r[1:0], b[7:4]}};
        if (fin) begin
          q_wdata.syms[1]  = '{pad: 1'b0, idx: {b[3:0], 2'b00}};
          q_wdata.syms[2]  = '{pad: 1'b1, idx: 6'd0};
          q_wdata.last_idx = b64enc_pkg::SYM_IDX_W'(2);
        end else begin
          q_wdata.last_idx = b64enc_pkg::SYM_IDX_W'(0);
          carry_nxt        = b[3:0];
          phase_nxt        = PH_2;
        end
      end
      PH_2: begin
        // The group completes here, so the state returns to its start.
        q_wdata.syms[0]  = '{pad: 1'b0, idx: {carry_r, b[7:6]}};
        q_wdata.syms[1]  = '{pad: 1'b0, idx: b[5:0]};
        q_wdata.last_idx = b64enc_pkg::SYM_IDX_W'(1);
      end
      default: begin
        // Start of a group; an unused phase code is treated the same way.
        q_wdata.syms[0] = '{pad: 1'b0, idx: b[7:2]};
        if (fin) begin
          q_wdata.syms[1]  = '{pad: 1'b0, idx: {b[1:0], 4'b0000}};
          q_wdata.syms[2]  = '{pad: 1'b1, idx: 6'd0};
          q_wdata.syms[3]  = '{pad: 1'b1, idx: 6'd0};
          q_wdata.last_idx = b64enc_pkg::SYM_IDX_W'(3);
        end else begin
          q_wdata.last_idx = b64enc_pkg::SYM_IDX_W'(0);
          carry_nxt        = {2'b00, b[1:0]};
          phase_nxt        = PH_1;
        end
      end
    endcase
    // A final byte always ends the message and clears the state.
    if (fin) begin
      phase_nxt = PH_0;
      carry_nxt = 4'd0;
    end
  end

  // Phase and carry advance on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_0;
      carry_r <= 4'd0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/b64enc_queue.sv =====
// Short queue of character entries between the front and the back.
// Uses entry and status types from b64enc_pkg.
`default_nettype none

module b64enc_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire b64enc_pkg::entry_t   wdata,
  input  wire logic                 pop,
  output b64enc_pkg::entry_t        rdata,
  output b64enc_pkg::queue_stat_t   stat
);

  localparam int unsigned LAST_SLOT = b64enc_pkg::QUEUE_DEPTH - 1;

  b64enc_pkg::entry_t                    slots_r [b64enc_pkg::QUEUE_DEPTH];
  logic [b64enc_pkg::QUEUE_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [b64enc_pkg::QUEUE_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [b64enc_pkg::QUEUE_CNT_W-1:0]    count_r, count_nxt;

  assign stat.full  = (count_r == b64enc_pkg::QUEUE_CNT_W'(b64enc_pkg::QUEUE_DEPTH));
  assign stat.valid = (count_r != '0);
  assign rdata      = slots_r[rd_ptr_r];

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == b64enc_pkg::QUEUE_PTR_W'(LAST_SLOT)) ? '0
                                                                     : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == b64enc_pkg::QUEUE_PTR_W'(LAST_SLOT)) ? '0
                                                                     : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage holds payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/b64enc_back.sv =====
// Back of the encoder: takes queue entries and sends their characters one
// beat at a time through an output register. Uses b64enc_pkg.
`default_nettype none

module b64enc_back (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire b64enc_pkg::queue_stat_t q_stat,
  input  wire b64enc_pkg::entry_t      q_rdata,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output b64enc_pkg::out_beat_t        out_data
);

  b64enc_pkg::entry_t                  cur_r;
  logic                                busy_r;
  logic [b64enc_pkg::SYM_IDX_W-1:0]    idx_r;
  logic                                out_valid_r;
  b64enc_pkg::out_beat_t               out_data_r;
  b64enc_pkg::sym_t                    sym;
  logic                                adv;
  logic                                emit;
  logic                                done;

  // The output register is free when empty or being drained this cycle.
  assign adv   = !out_valid_r || out_ready;
  assign emit  = busy_r && adv;
  assign done  = emit && (idx_r == cur_r.last_idx);
  // The next entry loads as the current one sends its last character.
  assign q_pop = q_stat.valid && (!busy_r || done);
  assign sym   = cur_r.syms[idx_r];

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Current entry and position within it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (emit) begin
      idx_r  <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_rdata;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Character lookup into the output register.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.out_char <= sym.pad ? b64enc_pkg::PAD_CHAR
                                     : b64enc_pkg::sym_to_ascii(sym.idx);
      out_data_r.out_last <= (idx_r == cur_r.last_idx) && cur_r.fin;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/base64_stream_encoder.sv =====
// Base64 (standard alphabet) stream encoder, top level: front, queue and back.
// Depends on b64enc_pkg, b64enc_front, b64enc_queue and b64enc_back.
//
// Bytes enter one per beat on in_*, with end_of_message set on the final byte
// of each message; characters leave one per beat on out_*, with out_last on
// the final character. A byte yields one or two characters, and a final byte
// that leaves a partial group yields three or four, padded with '='. The output
// port sends at most one character per cycle, so the sustained rate is set by
// the back's serializer, which sends four characters per three bytes in
// mid-message and up to four characters for a final byte. A two-entry queue
// lets the front take new bytes while the back is still sending or stalled; a
// byte's first character passes through the queue, the back's entry register
// and the output register. After reset the block is ready at once.
`default_nettype none

module base64_stream_encoder (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire b64enc_pkg::in_beat_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output b64enc_pkg::out_beat_t      out_data
);

  b64enc_pkg::queue_stat_t q_stat;
  b64enc_pkg::entry_t      q_wdata;
  b64enc_pkg::entry_t      q_rdata;
  logic                    q_push;
  logic                    q_pop;

  b64enc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  b64enc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  b64enc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The queue never takes an entry while full.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  // The back only pulls an entry that is present.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.valid)
    else $error("queue pop while empty");

  // A pop from a queue that is not full leaves it not full on the next cycle.
  a_out_from_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !q_stat.full) |=> !q_stat.full)
    else $error("queue occupancy rose across a pop");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for base64_stream_encoder: directed table, then random messages.
// Depends on b64enc_pkg for the beat types and the pad code, and on the encoder RTL.
`timescale 1ns / 1ps

module testbench;

  // Standard alphabet, first character in the top byte.
  localparam logic [511:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int NUM_DIRECTED = 23;
  localparam int PHASE_BYTES  = 33;
  localparam int MAX_SHOWN    = 10;

  // One row of the directed table; a zero length means the predictor decides.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        end_of_message;
    logic [2:0]  ref_len;
    logic [31:0] ref_text;
  } dir_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  b64enc_pkg::in_beat_t  in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  b64enc_pkg::out_beat_t out_data;

  // Encoder state mirrored by the predictor.
  logic [1:0] grp_phase = 2'd0;
  logic [3:0] carry_nib = 4'd0;

  b64enc_pkg::out_beat_t fresh_chars[$];
  b64enc_pkg::out_beat_t pending_chars[$];
  dir_row_t              directed_rows[NUM_DIRECTED];

  int tx_idle_pct    = 22;
  int rx_idle_pct    = 81;
  int mismatch_count = 0;
  int bytes_sent     = 0;
  int messages_sent  = 0;
  int chars_checked  = 0;

  base64_stream_encoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Maps a six-bit group onto its alphabet character.
  function automatic logic [7:0] alpha_char(input logic [5:0] v);
    alpha_char = B64_ALPHABET[8 * (63 - v) +: 8];
  endfunction

  task automatic add_char(input logic [7:0] ch, input logic last);
    b64enc_pkg::out_beat_t c;
    c.out_char = ch;
    c.out_last = last;
    fresh_chars.push_back(c);
  endtask

  // Predicts the characters one byte produces and advances the group state.
  task automatic encode_byte(input b64enc_pkg::in_beat_t beat);
    logic [7:0] b;
    logic       eom;
    b   = beat.data_byte;
    eom = beat.end_of_message;
    fresh_chars.delete();
    case (grp_phase)
      2'd1: begin
        add_char(alpha_char({carry_nib[1:0], b[7:4]}), 1'b0);
        if (eom) begin
          add_char(alpha_char({b[3:0], 2'b00}), 1'b0);
          add_char(b64enc_pkg::PAD_CHAR, 1'b1);
          grp_phase = 2'd0;
          carry_nib = 4'd0;
        end else begin
          carry_nib = b[3:0];
          grp_phase = 2'd2;
        end
      end
      2'd2: begin
        add_char(alpha_char({carry_nib, b[7:6]}), 1'b0);
        add_char(alpha_char(b[5:0]), eom);
        grp_phase = 2'd0;
        carry_nib = 4'd0;
      end
      // Group start; a phase of three cannot arise and is handled the same way.
      default: begin
        add_char(alpha_char(b[7:2]), 1'b0);
        if (eom) begin
          add_char(alpha_char({b[1:0], 4'b0000}), 1'b0);
          add_char(b64enc_pkg::PAD_CHAR, 1'b0);
          add_char(b64enc_pkg::PAD_CHAR, 1'b1);
          grp_phase = 2'd0;
          carry_nib = 4'd0;
        end else begin
          carry_nib = {2'b00, b[1:0]};
          grp_phase = 2'd1;
        end
      end
    endcase
  endtask

  // Offers one byte beat after a random gap and records its expected characters.
  task automatic send_beat(input b64enc_pkg::in_beat_t beat, input logic [2:0] ref_len,
                           input logic [31:0] ref_text);
    b64enc_pkg::out_beat_t c;
    int k;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_byte(beat);
    if (ref_len != 3'd0) begin
      for (k = 0; k < ref_len; k++) begin
        c.out_char = ref_text[8 * (ref_len - 1 - k) +: 8];
        c.out_last = beat.end_of_message && (k == ref_len - 1);
        pending_chars.push_back(c);
      end
    end else begin
      foreach (fresh_chars[i]) pending_chars.push_back(fresh_chars[i]);
    end
    bytes_sent++;
    if (beat.end_of_message) messages_sent++;
  endtask

  // Holds the input off until every expected character has come out.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // Sends random messages until the phase has used its share of bytes.
  task automatic send_random_phase(input int byte_budget);
    b64enc_pkg::in_beat_t beat;
    int len;
    int sent;
    int i;
    sent = 0;
    while (sent < byte_budget) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 10) : $urandom_range(9, 1);
      for (i = 0; i < len; i++) begin
        case ($urandom_range(7))
          0:       beat.data_byte = 8'h00;
          1:       beat.data_byte = 8'hFF;
          default: beat.data_byte = 8'($urandom_range(255));
        endcase
        beat.end_of_message = (i == len - 1);
        send_beat(beat, 3'd0, 32'd0);
      end
      sent += len;
    end
  endtask

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic report_mismatch(input string what, input b64enc_pkg::out_beat_t want,
                                 input b64enc_pkg::out_beat_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) begin
      $display("[%0t] %s: expected char 0x%02h last %0b, got char 0x%02h last %0b",
               $time, what, want.out_char, want.out_last, got.out_char, got.out_last);
    end
  endtask

  // Compares each output beat with the oldest expected character.
  always @(posedge clk) begin
    b64enc_pkg::out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      chars_checked++;
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected character", '0, out_data);
      end else begin
        want = pending_chars.pop_front();
        if (out_data.out_char !== want.out_char || out_data.out_last !== want.out_last) begin
          report_mismatch("character mismatch", want, out_data);
        end
      end
    end
  end

  // Directed rows: pads, all-zero and all-one bytes, the "Man" group and its short forms.
  initial begin
    directed_rows = '{
      '{8'h00, 1'b1, 3'd4, "AA=="},
      '{8'hFF, 1'b1, 3'd4, "/w=="},
      '{8'h4D, 1'b0, 3'd1, "T"},
      '{8'h61, 1'b0, 3'd1, "W"},
      '{8'h6E, 1'b1, 3'd2, "Fu"},
      '{8'h4D, 1'b0, 3'd1, "T"},
      '{8'h61, 1'b1, 3'd3, "WE="},
      '{8'hFF, 1'b0, 3'd1, "/"},
      '{8'hFF, 1'b0, 3'd1, "/"},
      '{8'hFF, 1'b1, 3'd2, "//"},
      '{8'h00, 1'b0, 3'd1, "A"},
      '{8'h00, 1'b1, 3'd3, "AA="},
      '{8'hFB, 1'b0, 3'd0, 32'd0},
      '{8'hFF, 1'b0, 3'd0, 32'd0},
      '{8'hBF, 1'b0, 3'd0, 32'd0},
      '{8'h80, 1'b0, 3'd0, 32'd0},
      '{8'h01, 1'b0, 3'd0, 32'd0},
      '{8'h7F, 1'b1, 3'd0, 32'd0},
      '{8'h55, 1'b0, 3'd0, 32'd0},
      '{8'hAA, 1'b0, 3'd0, 32'd0},
      '{8'h3C, 1'b0, 3'd0, 32'd0},
      '{8'hC3, 1'b1, 3'd0, 32'd0},
      '{8'h01, 1'b1, 3'd0, 32'd0}
    };
  end

  // Main sequence: reset, directed table, three random phases, then the verdict.
  initial begin
    b64enc_pkg::in_beat_t beat;
    int r;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < NUM_DIRECTED; r++) begin
      beat.data_byte      = directed_rows[r].data_byte;
      beat.end_of_message = directed_rows[r].end_of_message;
      send_beat(beat, directed_rows[r].ref_len, directed_rows[r].ref_text);
    end
    drain_outputs();

    send_random_phase(PHASE_BYTES);
    drain_outputs();

    tx_idle_pct = 81;
    rx_idle_pct = 22;
    send_random_phase(PHASE_BYTES);
    drain_outputs();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_phase(PHASE_BYTES);
    in_valid <= 1'b0;

    // Let the queue empty, then watch for stray output.
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (pending_chars.size() != 0) mismatch_count++;
    $display("Sent %0d bytes in %0d messages and checked %0d characters.",
             bytes_sent, messages_sent, chars_checked);
    $display("Stall mixes: sender-light, receiver-light and none; mismatches: %0d.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/b64enc_pkg.sv
hdl/b64enc_front.sv
hdl/b64enc_queue.sv
hdl/b64enc_back.sv
hdl/base64_stream_encoder.sv
bench/testbench.sv
